>>> hw/rtl/cst_pkg.sv
// Package for the cross stencil threshold block: widths, defaults, register codes and types.
package cst_pkg;

  // Default line store depth and frame height limit.
  localparam int unsigned CST_MAX_COLUMNS = 1024;
  localparam int unsigned CST_MAX_ROWS    = 1024;

  // Fixed field widths.
  localparam int unsigned PIXEL_W   = 8;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned POS_OUT_W = 10;
  localparam int unsigned SUM_W     = 11;
  localparam int unsigned LINE_W    = 2 * PIXEL_W;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values.
  localparam logic [CFG_W-1:0] ROW_COUNT_RESET      = 11'd10;
  localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET   = 11'd10;
  localparam logic [CFG_W-1:0] MARK_THRESHOLD_RESET = 11'd30;

  // Smallest frame dimension the window can work on.
  localparam int unsigned MIN_DIM = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT      = 2'd0,
    REG_COLUMN_COUNT   = 2'd1,
    REG_MARK_THRESHOLD = 2'd2
  } cst_reg_e;

  // One line store entry: the pixel of the row above and of the row above that.
  typedef struct packed {
    logic [PIXEL_W-1:0] prev;
    logic [PIXEL_W-1:0] older;
  } cst_line_t;

  // Per-pixel verdict of the raster tracker.
  typedef struct packed {
    logic judge;
    logic last;
  } cst_pos_t;

  // Clamp a programmed dimension into the range the hardware supports.
  function automatic int unsigned cst_clamp_dim(logic [CFG_W-1:0] v, int unsigned max_dim);
    int unsigned val;
    val = int'(v);
    if (val < MIN_DIM) begin
      return MIN_DIM;
    end
    if (val > max_dim) begin
      return max_dim;
    end
    return val;
  endfunction

endpackage

>>> hw/rtl/cross_stencil_threshold.sv
// Top level of the cross stencil threshold block: line store, window and result stage.
//
// Pixels arrive in raster order, one beat per clock while the result channel
// keeps up, and each pixel completing the plus-shaped window of an interior
// pixel one row up gives one result beat via the read stage and output
// register. Both line stores share one memory of MAX_COLUMNS entries, each
// holding the pixel of the row above and of the row above that; every pixel
// reads its own column and the next one at once and writes its own column back
// as its stage moves on, which allows one pixel per clock. The memory is not
// cleared after reset: the first two rows of a frame give no results, and by
// then every entry the window needs has been written. A result waiting in the
// output register does not stop the input while the stage before it is free.
module cross_stencil_threshold import cst_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = CST_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = CST_MAX_ROWS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Pixel input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PIXEL_W-1:0]   pixel_value_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 is_marked_o,
  output logic [POS_OUT_W-1:0] center_row_o,
  output logic [POS_OUT_W-1:0] center_column_o,
  output logic                 frame_last_o
);

  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RDW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CDW = $clog2(MAX_COLUMNS + 1);

  logic [RDW-1:0]       rows;
  logic [CDW-1:0]       cols;
  logic [CFG_W-1:0]     threshold;

  logic                 in_accept;
  logic [CW-1:0]        a_col;
  logic [POS_OUT_W-1:0] a_row;
  cst_pos_t             a_flags;

  logic [LINE_W-1:0]    rd_here_raw, rd_right_raw;
  cst_line_t            rd_here, rd_right;
  cst_line_t            wr_line;
  logic                 ram_we;

  // Stage holding the pixel whose line store data is being read.
  logic                 b_valid_q, b_valid_d;
  cst_pos_t             b_flags_q;
  logic [PIXEL_W-1:0]   b_px_q;
  logic [CW-1:0]        b_col_q;
  logic [POS_OUT_W-1:0] b_row_q;
  logic [PIXEL_W-1:0]   left_q, left_d;
  logic                 b_move;

  logic [SUM_W-1:0]     sum;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic                 out_marked_q;
  logic [POS_OUT_W-1:0] out_row_q;
  logic [POS_OUT_W-1:0] out_col_q;
  logic                 out_last_q;
  logic                 out_load;

  cst_cfg #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .rows_o      (rows),
    .cols_o      (cols),
    .threshold_o (threshold)
  );

  cst_raster #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_raster (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (in_accept),
    .rows_i       (rows),
    .cols_i       (cols),
    .col_o        (a_col),
    .center_row_o (a_row),
    .flags_o      (a_flags)
  );

  // The stage moves on unless it holds a result and the output is still full.
  assign b_move     = !b_valid_q || !b_flags_q.judge || !out_valid_q || out_ready_i;
  assign in_ready_o = b_move;
  assign in_accept  = in_valid_i && in_ready_o;

  // Line store: read own column and the one to the right on acceptance,
  // write own column back when the stage moves on.
  assign ram_we        = b_valid_q && b_move;
  assign rd_here       = cst_line_t'(rd_here_raw);
  assign rd_right      = cst_line_t'(rd_right_raw);
  assign wr_line.prev  = b_px_q;
  assign wr_line.older = rd_here.prev;

  cst_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (b_col_q),
    .wdata_i   (LINE_W'(wr_line)),
    .re_i      (in_accept),
    .raddr_a_i (a_col),
    .raddr_b_i (a_col + CW'(1)),
    .rdata_a_o (rd_here_raw),
    .rdata_b_o (rd_right_raw)
  );

  // Five-point sum: above, left, centre, right and below.
  assign sum = SUM_W'(rd_here.older) + SUM_W'(left_q) + SUM_W'(rd_here.prev) +
               SUM_W'(rd_right.prev) + SUM_W'(b_px_q);

  // Stage control and the left neighbour, which is the previous centre.
  always_comb begin
    b_valid_d = b_valid_q;
    left_d    = left_q;
    if (b_move) begin
      b_valid_d = in_accept;
      if (b_valid_q) begin
        left_d = rd_here.prev;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      b_flags_q <= '0;
      left_q    <= '0;
    end else begin
      b_valid_q <= b_valid_d;
      left_q    <= left_d;
      if (in_accept) begin
        b_flags_q <= a_flags;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      b_px_q  <= pixel_value_i;
      b_col_q <= a_col;
      b_row_q <= a_row;
    end
  end

  // Output register with handshake.
  assign out_load = b_valid_q && b_flags_q.judge && b_move;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_marked_q <= sum > threshold;
      out_row_q    <= b_row_q;
      out_col_q    <= POS_OUT_W'(b_col_q);
      out_last_q   <= b_flags_q.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign is_marked_o     = out_marked_q;
  assign center_row_o    = out_row_q;
  assign center_column_o = out_col_q;
  assign frame_last_o    = out_last_q;

endmodule

>>> hw/rtl/cst_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module cst_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two read ports; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hw/rtl/cst_cfg.sv
// Configuration registers of the cross stencil threshold block.
module cst_cfg import cst_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = CST_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = CST_MAX_ROWS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]               cfg_index_i,
  input  logic [CFG_W-1:0]                   cfg_data_i,
  output logic                               cfg_ready_o,
  output logic [$clog2(MAX_ROWS+1)-1:0]      rows_o,
  output logic [$clog2(MAX_COLUMNS+1)-1:0]   cols_o,
  output logic [CFG_W-1:0]                   threshold_o
);

  localparam int unsigned RDW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CDW = $clog2(MAX_COLUMNS + 1);

  logic [RDW-1:0]   rows_q, rows_d;
  logic [CDW-1:0]   cols_q, cols_d;
  logic [CFG_W-1:0] thr_q, thr_d;
  logic             wr_en;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i;

  // Register decode; dimensions are stored already clamped.
  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    thr_d  = thr_q;
    if (wr_en) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT:      rows_d = RDW'(cst_clamp_dim(cfg_data_i, MAX_ROWS));
        REG_COLUMN_COUNT:   cols_d = CDW'(cst_clamp_dim(cfg_data_i, MAX_COLUMNS));
        REG_MARK_THRESHOLD: thr_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RDW'(cst_clamp_dim(ROW_COUNT_RESET, MAX_ROWS));
      cols_q <= CDW'(cst_clamp_dim(COLUMN_COUNT_RESET, MAX_COLUMNS));
      thr_q  <= MARK_THRESHOLD_RESET;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      thr_q  <= thr_d;
    end
  end

  assign rows_o      = rows_q;
  assign cols_o      = cols_q;
  assign threshold_o = thr_q;

endmodule

>>> hw/rtl/cst_raster.sv
// Raster position tracker: row and column of the next pixel and its window verdict.
module cst_raster import cst_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = CST_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = CST_MAX_ROWS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               advance_i,
  input  logic [$clog2(MAX_ROWS+1)-1:0]      rows_i,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]   cols_i,
  output logic [$clog2(MAX_COLUMNS)-1:0]     col_o,
  output logic [POS_OUT_W-1:0]               center_row_o,
  output cst_pos_t                           flags_o
);

  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned RDW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CDW = $clog2(MAX_COLUMNS + 1);
  // One spare bit so that position plus two never wraps.
  localparam int unsigned CXW = CDW + 1;
  localparam int unsigned RXW = RDW + 1;

  logic [RW-1:0]  row_q, row_d;
  logic [CW-1:0]  col_q, col_d;
  logic [CXW-1:0] col_x, cols_x;
  logic [RXW-1:0] row_x, rows_x;
  logic           col_end, row_end;

  assign col_x  = CXW'(col_q);
  assign cols_x = CXW'(cols_i);
  assign row_x  = RXW'(row_q);
  assign rows_x = RXW'(rows_i);

  assign col_end = (col_x + CXW'(1)) >= cols_x;
  assign row_end = (row_x + RXW'(1)) >= rows_x;

  // The centre one row up is interior when the current pixel lies below the
  // top two rows and away from the left and right borders.
  always_comb begin
    flags_o.judge = (row_x >= RXW'(2)) && (row_x < rows_x) &&
                    (col_x >= CXW'(1)) && ((col_x + CXW'(2)) <= cols_x);
    flags_o.last  = ((row_x + RXW'(1)) == rows_x) && ((col_x + CXW'(2)) == cols_x);
  end

  assign col_o        = col_q;
  assign center_row_o = POS_OUT_W'(row_q - RW'(1));

  // Advance through the frame, wrapping at row and frame ends.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (advance_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule
